// ===== rtl/huffman_code_bit_packer_assert.svh =====
// ---------------------------------------------------------------------------
// huffman code bit packer assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HCBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HCBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HCBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define HCBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/hcbp_pkg.sv =====
// ---------------------------------------------------------------------------
// hcbp_pkg
// shared constants, function codes and the result batch type
// ---------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int BYTE_W  = 8;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int PEND_W  = BYTE_W - 1;
  localparam int CNT_W   = 3;
  localparam int PAD_W   = 3;
  localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // longest code that a load can store
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  // most bytes that one encode item can complete
  localparam int MAX_BYTES = (PEND_W + LEN_LIMIT) / BYTE_W;
  // left aligned work word: pending bits followed by a shifted code
  localparam int ACC_W     = CODE_W + BYTE_W;
  localparam int TOTAL_W   = $clog2(PEND_W + LEN_LIMIT + 1);
  localparam int NB_W      = $clog2(MAX_BYTES + 1);
  localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  // results caused by one item, handed from the packer to the emitter
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [NB_W-1:0]                  count;
    logic                             has_byte;
    logic                             is_final;
    logic [PAD_W-1:0]                 pad;
  } batch_t;

endpackage

`default_nettype wire

// ===== rtl/hcbp_ram.sv =====
// ---------------------------------------------------------------------------
// hcbp_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]               wdata_i,
  input  wire logic                           re_i,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr_i,
  output logic      [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/hcbp_table.sv =====
// ---------------------------------------------------------------------------
// hcbp_table
// code and length table with per entry valid bits and load formatting
// ---------------------------------------------------------------------------
`default_nettype none
`include "huffman_code_bit_packer_assert.svh"

module hcbp_table (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_req_i,
  input  wire logic                        rd_req_i,
  input  wire logic [hcbp_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic [hcbp_pkg::CODE_W-1:0] code_value_i,
  input  wire logic [hcbp_pkg::LEN_W-1:0]  code_len_i,
  output logic      [hcbp_pkg::CODE_W-1:0] code_o,
  output logic      [hcbp_pkg::LEN_W-1:0]  len_o
);

  logic                          in_range;
  logic [hcbp_pkg::ADDR_W-1:0]   addr;
  logic                          wr_en;
  logic                          rd_en;
  logic [hcbp_pkg::LEN_W-1:0]    len_sat;
  logic [hcbp_pkg::CODE_W-1:0]   code_mask;
  logic [hcbp_pkg::LEN_W-1:0]    len_ram;
  logic [hcbp_pkg::SYMBOL_COUNT-1:0] valid_q;
  logic                          hit_q;

  assign in_range = {1'b0, symbol_i} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT);
  assign addr     = symbol_i[hcbp_pkg::ADDR_W-1:0];
  assign wr_en    = wr_req_i && in_range;
  assign rd_en    = rd_req_i;

  // saturate the length, keep only the code bits it covers
  assign len_sat   = (code_len_i > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT)) ?
                     hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT) : code_len_i;
  assign code_mask = ~({hcbp_pkg::CODE_W{1'b1}} << len_sat);

  hcbp_ram #(
    .WIDTH (hcbp_pkg::CODE_W),
    .DEPTH (hcbp_pkg::SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr),
    .wdata_i (code_value_i & code_mask),
    .re_i    (rd_en),
    .raddr_i (addr),
    .rdata_o (code_o)
  );

  hcbp_ram #(
    .WIDTH (hcbp_pkg::LEN_W),
    .DEPTH (hcbp_pkg::SYMBOL_COUNT)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr),
    .wdata_i (len_sat),
    .re_i    (rd_en),
    .raddr_i (addr),
    .rdata_o (len_ram)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= valid_q[addr] && in_range;
      end
    end
  end

  // never loaded entries read as empty codes
  assign len_o = hit_q ? len_ram : '0;

  `HCBP_ASSERT_NXT(a_load_sets_valid, clk_i, rst_ni, wr_en, valid_q[$past(addr)],
                   "loaded entry not marked valid")

endmodule

`default_nettype wire

// ===== rtl/hcbp_pack.sv =====
// ---------------------------------------------------------------------------
// hcbp_pack
// merges a code with the pending bits and cuts out the complete bytes, or flushes them
// ---------------------------------------------------------------------------
`default_nettype none
`include "huffman_code_bit_packer_assert.svh"

module hcbp_pack (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire hcbp_pkg::func_e             func_i,
  input  wire logic [hcbp_pkg::CODE_W-1:0] code_i,
  input  wire logic [hcbp_pkg::LEN_W-1:0]  len_i,
  output hcbp_pkg::batch_t                 batch_o,
  output logic                             produce_o
);

  // pending bits are kept left aligned, unused low bits zero
  logic [hcbp_pkg::PEND_W-1:0]  pend_q, pend_d;
  logic [hcbp_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  logic [hcbp_pkg::CODE_W-1:0]  code_al;
  logic [hcbp_pkg::ACC_W-1:0]   acc;
  logic [hcbp_pkg::TOTAL_W-1:0] total;
  logic [hcbp_pkg::NB_W-1:0]    n_bytes;
  logic [hcbp_pkg::PEND_W-1:0]  pend_enc;

  assign code_al = code_i << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - len_i);
  assign acc     = {pend_q, (hcbp_pkg::ACC_W - hcbp_pkg::PEND_W)'(0)}
                 | ({code_al, hcbp_pkg::BYTE_W'(0)} >> cnt_q);
  assign total   = hcbp_pkg::TOTAL_W'(cnt_q) + hcbp_pkg::TOTAL_W'(len_i);
  assign n_bytes = hcbp_pkg::NB_W'(total >> 3);

  always_comb begin
    pend_enc = '0;
    for (int j = 0; j <= hcbp_pkg::MAX_BYTES; j++) begin
      if (n_bytes == hcbp_pkg::NB_W'(j)) begin
        pend_enc = acc[hcbp_pkg::ACC_W-1-hcbp_pkg::BYTE_W*j -: hcbp_pkg::PEND_W];
      end
    end
  end

  always_comb begin
    batch_o   = '0;
    produce_o = 1'b0;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    case (func_i)
      hcbp_pkg::FUNC_ENCODE: begin
        for (int j = 0; j < hcbp_pkg::MAX_BYTES; j++) begin
          batch_o.bytes[j] = acc[hcbp_pkg::ACC_W-1-hcbp_pkg::BYTE_W*j -: hcbp_pkg::BYTE_W];
        end
        batch_o.count    = n_bytes;
        batch_o.has_byte = 1'b1;
        produce_o        = (n_bytes != '0);
        pend_d           = pend_enc;
        cnt_d            = total[hcbp_pkg::CNT_W-1:0];
      end
      hcbp_pkg::FUNC_FLUSH: begin
        batch_o.bytes[0] = {pend_q, 1'b0};
        batch_o.count    = hcbp_pkg::NB_W'(1);
        batch_o.has_byte = (cnt_q != '0);
        batch_o.is_final = 1'b1;
        // eight minus the count, zero when nothing is pending
        batch_o.pad      = hcbp_pkg::PAD_W'((hcbp_pkg::PAD_W + 1)'(hcbp_pkg::BYTE_W)
                                            - {1'b0, cnt_q});
        produce_o        = 1'b1;
        pend_d           = '0;
        cnt_d            = '0;
      end
      default: begin
        produce_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  `HCBP_ASSERT_IMP(a_pend_clean, clk_i, rst_ni, cnt_q == '0, pend_q == '0,
                   "stale bits left in empty accumulator")

endmodule

`default_nettype wire

// ===== rtl/hcbp_emit.sv =====
// ---------------------------------------------------------------------------
// hcbp_emit
// holds one batch of results and hands them out one item per cycle while out_ready_i is high
// ---------------------------------------------------------------------------
`default_nettype none
`include "huffman_code_bit_packer_assert.svh"

module hcbp_emit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire hcbp_pkg::batch_t              batch_i,
  output logic                               free_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [hcbp_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                               has_byte_o,
  output logic                               is_final_o,
  output logic      [hcbp_pkg::PAD_W-1:0]    pad_bits_o,
  output logic                               last_o
);

  logic                       valid_q;
  logic [hcbp_pkg::IDX_W-1:0] idx_q;
  hcbp_pkg::batch_t           batch_q;
  logic                       is_last;

  assign is_last = (hcbp_pkg::NB_W'(idx_q) + hcbp_pkg::NB_W'(1)) == batch_q.count;
  assign free_o  = !valid_q || (out_ready_i && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (free_o) begin
      valid_q <= load_i;
      idx_q   <= '0;
    end else if (out_ready_i) begin
      idx_q   <= idx_q + hcbp_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      batch_q <= batch_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = batch_q.bytes[idx_q];
  assign has_byte_o  = batch_q.has_byte;
  assign is_final_o  = batch_q.is_final;
  assign pad_bits_o  = batch_q.pad;
  assign last_o      = is_last;

  `HCBP_ASSERT_IMP(a_idx_in_batch, clk_i, rst_ni, valid_q,
                   hcbp_pkg::NB_W'(idx_q) < batch_q.count,
                   "emit index past end of batch")
  `HCBP_ASSERT_NXT(a_batch_held, clk_i, rst_ni, valid_q && !is_last, valid_q,
                   "batch dropped before its last item")

endmodule

`default_nettype wire

// ===== rtl/huffman_code_bit_packer.sv =====
// ---------------------------------------------------------------------------
// huffman_code_bit_packer
// huffman encoder with a loaded code table, packing code bits into bytes
// ---------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// in       input      in_valid_i/in_ready_o  func_i symbol_i code_value_i code_len_i
// out      output     out_valid_o/out_ready_i out_byte_o has_byte_o is_final_o
//                                            pad_bits_o last_o
//
// an item reads the table when it is accepted, is packed in the packing stage
// from the registered table data, and its results go to the result register,
// which hands them out one byte at a time, up to four for an encode and one
// for a flush; the packing stage may hold the next item meanwhile
// loads, empty codes and encodes that complete no byte make no result
// reset clears the pending bits and the table valid bits at once, no sweep
// a stalled result holds the packing stage, which in turn holds the input
// ---------------------------------------------------------------------------
`default_nettype none
`include "huffman_code_bit_packer_assert.svh"

module huffman_code_bit_packer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [hcbp_pkg::SYM_W-1:0]    symbol_i,
  input  wire logic [hcbp_pkg::CODE_W-1:0]   code_value_i,
  input  wire logic [hcbp_pkg::LEN_W-1:0]    code_len_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [hcbp_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                               has_byte_o,
  output logic                               is_final_o,
  output logic      [hcbp_pkg::PAD_W-1:0]    pad_bits_o,
  output logic                               last_o
);

  hcbp_pkg::func_e             func_in;
  logic                        accept;

  // packing stage control
  logic                        s1_valid_q;
  hcbp_pkg::func_e             s1_func_q;
  logic                        s1_fire;

  logic [hcbp_pkg::CODE_W-1:0] tbl_code;
  logic [hcbp_pkg::LEN_W-1:0]  tbl_len;
  hcbp_pkg::batch_t            batch;
  logic                        produce;
  logic                        emit_free;

  assign func_in = hcbp_pkg::func_e'(func_i);

  // packing stage moves on when its item makes no result or the emitter takes it
  assign s1_fire    = s1_valid_q && (!produce || emit_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q <= func_in;
    end
  end

  // table: loads write at acceptance, encodes read with registered data
  hcbp_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_req_i     (accept && (func_in == hcbp_pkg::FUNC_LOAD)),
    .rd_req_i     (accept && (func_in == hcbp_pkg::FUNC_ENCODE)),
    .symbol_i     (symbol_i),
    .code_value_i (code_value_i),
    .code_len_i   (code_len_i),
    .code_o       (tbl_code),
    .len_o        (tbl_len)
  );

  // bit accumulator and byte cutter
  hcbp_pack u_pack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_fire),
    .func_i    (s1_func_q),
    .code_i    (tbl_code),
    .len_i     (tbl_len),
    .batch_o   (batch),
    .produce_o (produce)
  );

  // result register, one item per cycle while out_ready_i is high
  hcbp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire && produce),
    .batch_i     (batch),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .is_final_o  (is_final_o),
    .pad_bits_o  (pad_bits_o),
    .last_o      (last_o)
  );

  `HCBP_ASSERT_NXT(a_batch_shown, clk_i, rst_ni, s1_fire && produce, out_valid_o,
                   "packed batch not presented on the result channel")
  `HCBP_ASSERT_NXT(a_flush_final, clk_i, rst_ni,
                   s1_fire && (s1_func_q == hcbp_pkg::FUNC_FLUSH),
                   out_valid_o && is_final_o && last_o,
                   "flush result not marked final")

endmodule

`default_nettype wire
